// ----- rtl/ipk_pkg.sv -----
// Shared types and constants for the iambic paddle keyer.
// Holds the keyer phase encoding, request op codes, register map and register reset values.
// Used by iambic_paddle_keyer_core; depends on nothing.
`default_nettype none

package ipk_pkg;

   localparam int DUR_W  = 24;
   localparam int FREQ_W = 12;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;

   localparam logic OP_PADDLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_IN_DOT_A   = 4'd1,
      PH_IN_DASH_A  = 4'd2,
      PH_AFT_DOT_A  = 4'd3,
      PH_AFT_DASH_A = 4'd4,
      PH_IN_DOT_B   = 4'd5,
      PH_IN_DASH_B  = 4'd6,
      PH_AFT_DOT_B  = 4'd7,
      PH_AFT_DASH_B = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      LEN_DOT  = 2'd0,
      LEN_DASH = 2'd1,
      LEN_GAP  = 2'd2
   } len_sel_type;

   localparam logic [IDX_W-1:0] REG_MODE_B    = 3'd0;
   localparam logic [IDX_W-1:0] REG_DOT_DUR   = 3'd1;
   localparam logic [IDX_W-1:0] REG_DASH_DUR  = 3'd2;
   localparam logic [IDX_W-1:0] REG_GAP_DUR   = 3'd3;
   localparam logic [IDX_W-1:0] REG_TONE_FREQ = 3'd4;

   localparam logic [DUR_W-1:0]  RST_DOT_DUR   = 24'd100000;
   localparam logic [DUR_W-1:0]  RST_DASH_DUR  = 24'd300000;
   localparam logic [DUR_W-1:0]  RST_GAP_DUR   = 24'd100000;
   localparam logic [FREQ_W-1:0] RST_TONE_FREQ = 12'd800;

endpackage

`default_nettype wire

// ----- rtl/iambic_paddle_keyer_core.sv -----
// Iambic paddle keyer, mode A and mode B, with an APB-style register port.
// Depends on ipk_pkg for the phase encoding and the register map.
//
// Usage:
//   req_ channel: one beat is a paddle event (req_op 0, with both paddle
//   states) or an element-finished tick (req_op 1). rsp_ channel: one beat
//   is a tone request, issued only when the key state changes, so a request
//   beat gives zero or one response beat.
//   Each request beat is decided in the cycle it is accepted: keyer phase,
//   paddle latches and key state update at that edge, and the response beat,
//   if any, is valid from the next cycle. One request beat is taken every
//   cycle while the response register is empty or being drained; the
//   response register is the only stage between the channels.
//   When the receiver stalls with a response pending, req_ready drops until
//   that response is taken.
//   Reset returns the keyer to idle, latches cleared, key open, registers
//   at defaults. The user writes registers through csr_ only while no beat
//   is in flight (not enforced by the block); csr_pready is always high.
`default_nettype none

module iambic_paddle_keyer_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_op,
   input  wire logic                        req_dot_pressed,
   input  wire logic                        req_dash_pressed,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_key_closed,
   output logic [ipk_pkg::DUR_W-1:0]        rsp_duration_us,
   output logic [ipk_pkg::FREQ_W-1:0]       rsp_frequency_hz,
   output logic                             rsp_slope_standard,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [ipk_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [ipk_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [ipk_pkg::DATA_W-1:0]       csr_prdata,
   output logic                             csr_pready
);

   logic                         mode_b_ff;
   logic [ipk_pkg::DUR_W-1:0]    dot_dur_ff;
   logic [ipk_pkg::DUR_W-1:0]    dash_dur_ff;
   logic [ipk_pkg::DUR_W-1:0]    gap_dur_ff;
   logic [ipk_pkg::FREQ_W-1:0]   tone_freq_ff;

   ipk_pkg::phase_type           phase_ff, phase_in, phase_work;
   logic                         dot_held_ff, dot_held_in;
   logic                         dash_held_ff, dash_held_in;
   logic                         dot_armed_ff, dot_armed_in;
   logic                         dash_armed_ff, dash_armed_in;
   logic                         squeeze_ff, squeeze_in;
   logic                         key_ff, key_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_key_ff;
   logic [ipk_pkg::DUR_W-1:0]    rsp_dur_ff, rsp_dur_in;
   logic [ipk_pkg::FREQ_W-1:0]   rsp_freq_ff;

   logic                         accept;
   logic                         csr_write;
   logic [ipk_pkg::IDX_W-1:0]    csr_index;
   logic                         start;
   logic                         want_set;
   logic                         want_closed;
   ipk_pkg::len_sel_type         len_sel;
   logic                         emit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[ipk_pkg::ADDR_W-1:2];

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_b_ff    <= 1'b0;
         dot_dur_ff   <= ipk_pkg::RST_DOT_DUR;
         dash_dur_ff  <= ipk_pkg::RST_DASH_DUR;
         gap_dur_ff   <= ipk_pkg::RST_GAP_DUR;
         tone_freq_ff <= ipk_pkg::RST_TONE_FREQ;
      end else if (csr_write) begin
         case (csr_index)
            ipk_pkg::REG_MODE_B:    mode_b_ff    <= csr_pwdata[0];
            ipk_pkg::REG_DOT_DUR:   dot_dur_ff   <= csr_pwdata[ipk_pkg::DUR_W-1:0];
            ipk_pkg::REG_DASH_DUR:  dash_dur_ff  <= csr_pwdata[ipk_pkg::DUR_W-1:0];
            ipk_pkg::REG_GAP_DUR:   gap_dur_ff   <= csr_pwdata[ipk_pkg::DUR_W-1:0];
            ipk_pkg::REG_TONE_FREQ: tone_freq_ff <= csr_pwdata[ipk_pkg::FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ipk_pkg::REG_MODE_B:
            csr_prdata = {{(ipk_pkg::DATA_W-1){1'b0}}, mode_b_ff};
         ipk_pkg::REG_DOT_DUR:
            csr_prdata = {{(ipk_pkg::DATA_W-ipk_pkg::DUR_W){1'b0}}, dot_dur_ff};
         ipk_pkg::REG_DASH_DUR:
            csr_prdata = {{(ipk_pkg::DATA_W-ipk_pkg::DUR_W){1'b0}}, dash_dur_ff};
         ipk_pkg::REG_GAP_DUR:
            csr_prdata = {{(ipk_pkg::DATA_W-ipk_pkg::DUR_W){1'b0}}, gap_dur_ff};
         ipk_pkg::REG_TONE_FREQ:
            csr_prdata = {{(ipk_pkg::DATA_W-ipk_pkg::FREQ_W){1'b0}}, tone_freq_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   always_comb begin
      dot_held_in   = dot_held_ff;
      dash_held_in  = dash_held_ff;
      dot_armed_in  = dot_armed_ff;
      dash_armed_in = dash_armed_ff;
      squeeze_in    = squeeze_ff;
      phase_work    = phase_ff;
      start         = 1'b0;

      // paddle event: record paddles, set latches, start from idle
      if (req_op == ipk_pkg::OP_PADDLE) begin
         dot_held_in  = req_dot_pressed;
         dash_held_in = req_dash_pressed;
         if (req_dot_pressed) dot_armed_in = 1'b1;
         if (req_dash_pressed) dash_armed_in = 1'b1;
         if (mode_b_ff && req_dot_pressed && req_dash_pressed) squeeze_in = 1'b1;
         if (phase_ff == ipk_pkg::PH_IDLE) begin
            if (req_dot_pressed) begin
               start      = 1'b1;
               phase_work = squeeze_in ? ipk_pkg::PH_AFT_DASH_B : ipk_pkg::PH_AFT_DASH_A;
            end else if (req_dash_pressed) begin
               start      = 1'b1;
               phase_work = squeeze_in ? ipk_pkg::PH_AFT_DOT_B : ipk_pkg::PH_AFT_DOT_A;
            end
         end
      end

      phase_in    = phase_work;
      want_set    = 1'b0;
      want_closed = 1'b0;
      len_sel     = ipk_pkg::LEN_GAP;

      if ((req_op == ipk_pkg::OP_TICK) || start) begin
         case (phase_work)
            ipk_pkg::PH_IN_DOT_A, ipk_pkg::PH_IN_DOT_B: begin
               want_set = 1'b1;
               len_sel  = ipk_pkg::LEN_GAP;
               phase_in = (phase_work == ipk_pkg::PH_IN_DOT_A) ?
                          ipk_pkg::PH_AFT_DOT_A : ipk_pkg::PH_AFT_DOT_B;
            end
            ipk_pkg::PH_IN_DASH_A, ipk_pkg::PH_IN_DASH_B: begin
               want_set = 1'b1;
               len_sel  = ipk_pkg::LEN_GAP;
               phase_in = (phase_work == ipk_pkg::PH_IN_DASH_A) ?
                          ipk_pkg::PH_AFT_DASH_A : ipk_pkg::PH_AFT_DASH_B;
            end
            ipk_pkg::PH_AFT_DOT_A, ipk_pkg::PH_AFT_DOT_B: begin
               if (!dot_held_in) dot_armed_in = 1'b0;
               if (phase_work == ipk_pkg::PH_AFT_DOT_B) begin
                  want_set    = 1'b1;
                  want_closed = 1'b1;
                  len_sel     = ipk_pkg::LEN_DASH;
                  phase_in    = ipk_pkg::PH_IN_DASH_A;
               end else if (dash_armed_in) begin
                  want_set    = 1'b1;
                  want_closed = 1'b1;
                  len_sel     = ipk_pkg::LEN_DASH;
                  if (squeeze_in) begin
                     squeeze_in = 1'b0;
                     phase_in   = ipk_pkg::PH_IN_DASH_B;
                  end else begin
                     phase_in   = ipk_pkg::PH_IN_DASH_A;
                  end
               end else if (dot_armed_in) begin
                  want_set    = 1'b1;
                  want_closed = 1'b1;
                  len_sel     = ipk_pkg::LEN_DOT;
                  phase_in    = ipk_pkg::PH_IN_DOT_A;
               end else begin
                  phase_in    = ipk_pkg::PH_IDLE;
               end
            end
            ipk_pkg::PH_AFT_DASH_A, ipk_pkg::PH_AFT_DASH_B: begin
               if (!dash_held_in) dash_armed_in = 1'b0;
               if (phase_work == ipk_pkg::PH_AFT_DASH_B) begin
                  want_set    = 1'b1;
                  want_closed = 1'b1;
                  len_sel     = ipk_pkg::LEN_DOT;
                  phase_in    = ipk_pkg::PH_IN_DOT_A;
               end else if (dot_armed_in) begin
                  want_set    = 1'b1;
                  want_closed = 1'b1;
                  len_sel     = ipk_pkg::LEN_DOT;
                  if (squeeze_in) begin
                     squeeze_in = 1'b0;
                     phase_in   = ipk_pkg::PH_IN_DOT_B;
                  end else begin
                     phase_in   = ipk_pkg::PH_IN_DOT_A;
                  end
               end else if (dash_armed_in) begin
                  want_set    = 1'b1;
                  want_closed = 1'b1;
                  len_sel     = ipk_pkg::LEN_DASH;
                  phase_in    = ipk_pkg::PH_IN_DASH_A;
               end else begin
                  phase_in    = ipk_pkg::PH_IDLE;
               end
            end
            default: ;
         endcase
      end

      emit   = want_set && (want_closed != key_ff);
      key_in = emit ? want_closed : key_ff;

      case (len_sel)
         ipk_pkg::LEN_DOT:  rsp_dur_in = dot_dur_ff;
         ipk_pkg::LEN_DASH: rsp_dur_in = dash_dur_ff;
         default:           rsp_dur_in = gap_dur_ff;
      endcase

      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ipk_pkg::PH_IDLE;
         dot_held_ff   <= 1'b0;
         dash_held_ff  <= 1'b0;
         dot_armed_ff  <= 1'b0;
         dash_armed_ff <= 1'b0;
         squeeze_ff    <= 1'b0;
         key_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            dot_held_ff   <= dot_held_in;
            dash_held_ff  <= dash_held_in;
            dot_armed_ff  <= dot_armed_in;
            dash_armed_ff <= dash_armed_in;
            squeeze_ff    <= squeeze_in;
            key_ff        <= key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_key_ff  <= want_closed;
         rsp_dur_ff  <= rsp_dur_in;
         rsp_freq_ff <= want_closed ? tone_freq_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_closed     = rsp_key_ff;
   assign rsp_duration_us    = rsp_dur_ff;
   assign rsp_frequency_hz   = rsp_freq_ff;
   assign rsp_slope_standard = rsp_key_ff;

endmodule

`default_nettype wire

// ----- test/tb_iambic_paddle_keyer_core.sv -----
// Testbench for iambic_paddle_keyer_core: directed and random paddle and tick beats,
// tone requests checked against an in-bench keyer model under random stalls.
// Depends on ipk_pkg and the iambic_paddle_keyer_core RTL.
module tb_iambic_paddle_keyer_core;

   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 235;

   typedef struct packed {
      bit op;
      bit dot;
      bit dash;
   } beat_type;

   typedef struct packed {
      logic                       key_closed;
      logic [ipk_pkg::DUR_W-1:0]  duration;
      logic [ipk_pkg::FREQ_W-1:0] frequency;
      logic                       slope;
   } tone_type;

   logic                       clock              = 1'b0;
   logic                       reset              = 1'b1;
   logic                       req_valid          = 1'b0;
   logic                       req_ready;
   logic                       req_op             = 1'b0;
   logic                       req_dot_pressed    = 1'b0;
   logic                       req_dash_pressed   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready          = 1'b0;
   logic                       rsp_key_closed;
   logic [ipk_pkg::DUR_W-1:0]  rsp_duration_us;
   logic [ipk_pkg::FREQ_W-1:0] rsp_frequency_hz;
   logic                       rsp_slope_standard;
   logic                       csr_psel           = 1'b0;
   logic                       csr_penable        = 1'b0;
   logic                       csr_pwrite         = 1'b0;
   logic [ipk_pkg::ADDR_W-1:0] csr_paddr          = '0;
   logic [ipk_pkg::DATA_W-1:0] csr_pwdata         = '0;
   logic [ipk_pkg::DATA_W-1:0] csr_prdata;
   logic                       csr_pready;

   beat_type pending_beats[$];
   tone_type expected_tones[$];
   int       errors        = 0;
   int       beats_queued  = 0;

   int unsigned send_gap_max  = 0;
   int unsigned rsp_gap_max   = 0;
   int unsigned send_wait     = 0;
   int unsigned recv_wait     = 0;
   int unsigned rsp_hold_left = 0;
   logic        rsp_hold_req  = 1'b0;

   // keyer model state and register shadow
   ipk_pkg::phase_type         ph            = ipk_pkg::PH_IDLE;
   bit                         dot_held      = 1'b0;
   bit                         dash_held     = 1'b0;
   bit                         dot_armed     = 1'b0;
   bit                         dash_armed    = 1'b0;
   bit                         squeeze_latch = 1'b0;
   bit                         key_now       = 1'b0;
   bit                         cfg_mode_b    = 1'b0;
   logic [ipk_pkg::DUR_W-1:0]  cfg_dot       = ipk_pkg::RST_DOT_DUR;
   logic [ipk_pkg::DUR_W-1:0]  cfg_dash      = ipk_pkg::RST_DASH_DUR;
   logic [ipk_pkg::DUR_W-1:0]  cfg_gap       = ipk_pkg::RST_GAP_DUR;
   logic [ipk_pkg::FREQ_W-1:0] cfg_freq      = ipk_pkg::RST_TONE_FREQ;

   iambic_paddle_keyer_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_dot_pressed    (req_dot_pressed),
      .req_dash_pressed   (req_dash_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_closed     (rsp_key_closed),
      .rsp_duration_us    (rsp_duration_us),
      .rsp_frequency_hz   (rsp_frequency_hz),
      .rsp_slope_standard (rsp_slope_standard),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic bit key_change(bit closed, logic [ipk_pkg::DUR_W-1:0] len,
                                     output tone_type t);
      t = '0;
      if (closed == key_now) return 1'b0;
      key_now      = closed;
      t.key_closed = closed;
      t.duration   = len;
      t.frequency  = closed ? cfg_freq : '0;
      t.slope      = closed;
      return 1'b1;
   endfunction

   function automatic bit keyer_advance(output tone_type t);
      bit emit;
      emit = 1'b0;
      t    = '0;
      case (ph)
         ipk_pkg::PH_IN_DOT_A, ipk_pkg::PH_IN_DOT_B: begin
            emit = key_change(1'b0, cfg_gap, t);
            if (ph == ipk_pkg::PH_IN_DOT_A) ph = ipk_pkg::PH_AFT_DOT_A;
            else ph = ipk_pkg::PH_AFT_DOT_B;
         end
         ipk_pkg::PH_IN_DASH_A, ipk_pkg::PH_IN_DASH_B: begin
            emit = key_change(1'b0, cfg_gap, t);
            if (ph == ipk_pkg::PH_IN_DASH_A) ph = ipk_pkg::PH_AFT_DASH_A;
            else ph = ipk_pkg::PH_AFT_DASH_B;
         end
         ipk_pkg::PH_AFT_DOT_A, ipk_pkg::PH_AFT_DOT_B: begin
            if (!dot_held) dot_armed = 1'b0;
            if (ph == ipk_pkg::PH_AFT_DOT_B) begin
               emit = key_change(1'b1, cfg_dash, t);
               ph   = ipk_pkg::PH_IN_DASH_A;
            end else if (dash_armed) begin
               emit = key_change(1'b1, cfg_dash, t);
               if (squeeze_latch) begin
                  squeeze_latch = 1'b0;
                  ph            = ipk_pkg::PH_IN_DASH_B;
               end else begin
                  ph = ipk_pkg::PH_IN_DASH_A;
               end
            end else if (dot_armed) begin
               emit = key_change(1'b1, cfg_dot, t);
               ph   = ipk_pkg::PH_IN_DOT_A;
            end else begin
               ph = ipk_pkg::PH_IDLE;
            end
         end
         ipk_pkg::PH_AFT_DASH_A, ipk_pkg::PH_AFT_DASH_B: begin
            if (!dash_held) dash_armed = 1'b0;
            if (ph == ipk_pkg::PH_AFT_DASH_B) begin
               emit = key_change(1'b1, cfg_dot, t);
               ph   = ipk_pkg::PH_IN_DOT_A;
            end else if (dot_armed) begin
               emit = key_change(1'b1, cfg_dot, t);
               if (squeeze_latch) begin
                  squeeze_latch = 1'b0;
                  ph            = ipk_pkg::PH_IN_DOT_B;
               end else begin
                  ph = ipk_pkg::PH_IN_DOT_A;
               end
            end else if (dash_armed) begin
               emit = key_change(1'b1, cfg_dash, t);
               ph   = ipk_pkg::PH_IN_DASH_A;
            end else begin
               ph = ipk_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
      return emit;
   endfunction

   function automatic void predict_tone(bit op, bit dot, bit dash);
      tone_type t;
      bit       emit;
      emit = 1'b0;
      if (op == ipk_pkg::OP_TICK) begin
         emit = keyer_advance(t);
      end else begin
         dot_held  = dot;
         dash_held = dash;
         if (dot) dot_armed = 1'b1;
         if (dash) dash_armed = 1'b1;
         if (cfg_mode_b && dot && dash) squeeze_latch = 1'b1;
         if (ph == ipk_pkg::PH_IDLE && (dot || dash)) begin
            if (dot) begin
               if (squeeze_latch) ph = ipk_pkg::PH_AFT_DASH_B;
               else ph = ipk_pkg::PH_AFT_DASH_A;
            end else begin
               if (squeeze_latch) ph = ipk_pkg::PH_AFT_DOT_B;
               else ph = ipk_pkg::PH_AFT_DOT_A;
            end
            emit = keyer_advance(t);
         end
      end
      if (emit) expected_tones.push_back(t);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void push_beat(bit op, bit dot, bit dash);
      beat_type b;
      b.op   = op;
      b.dot  = dot;
      b.dash = dash;
      pending_beats.push_back(b);
      beats_queued++;
   endfunction

   task automatic csr_write(input logic [ipk_pkg::IDX_W-1:0] idx,
                            input logic [ipk_pkg::DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         ipk_pkg::REG_MODE_B:    cfg_mode_b = data[0];
         ipk_pkg::REG_DOT_DUR:   cfg_dot    = data[ipk_pkg::DUR_W-1:0];
         ipk_pkg::REG_DASH_DUR:  cfg_dash   = data[ipk_pkg::DUR_W-1:0];
         ipk_pkg::REG_GAP_DUR:   cfg_gap    = data[ipk_pkg::DUR_W-1:0];
         ipk_pkg::REG_TONE_FREQ: cfg_freq   = data[ipk_pkg::FREQ_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_tones.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      logic     valid_n;
      beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         valid_n = req_valid;
         if (req_valid && req_ready) begin
            predict_tone(req_op, req_dot_pressed, req_dash_pressed);
            valid_n = 1'b0;
         end
         if (!valid_n) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_beats.size() > 0) begin
               b = pending_beats.pop_front();
               req_op           <= b.op;
               req_dot_pressed  <= b.dot;
               req_dash_pressed <= b.dash;
               valid_n   = 1'b1;
               send_wait = $urandom_range(send_gap_max);
            end
         end
         req_valid <= valid_n;
      end
   end

   // response monitor
   always @(posedge clock) begin
      tone_type got;
      tone_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_key_closed, rsp_duration_us, rsp_frequency_hz, rsp_slope_standard};
            if (expected_tones.size() == 0) begin
               $display("%0t: unexpected tone beat, expected none, actual %p", $time, got);
               errors++;
            end else begin
               want = expected_tones.pop_front();
               check_field("key_closed", 32'(want.key_closed), 32'(got.key_closed));
               check_field("duration_us", 32'(want.duration), 32'(got.duration));
               check_field("frequency_hz", 32'(want.frequency), 32'(got.frequency));
               check_field("slope_standard", 32'(want.slope), 32'(got.slope));
            end
            recv_wait = $urandom_range(rsp_gap_max);
         end else if (rsp_valid && recv_wait > 0) begin
            recv_wait--;
         end
         rsp_ready <= (recv_wait == 0) && (rsp_hold_left == 0);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) rsp_hold_left <= 0;
      else if (rsp_hold_left > 0) rsp_hold_left <= rsp_hold_left - 1;
      else if (rsp_hold_req) rsp_hold_left <= HOLD_CYCLES;
   end

   initial begin
      int unsigned gap_choice[3];
      logic [ipk_pkg::DATA_W-1:0] mode_v, dot_v, dash_v, gap_v, freq_v;
      logic [1:0] pat;
      int phase_end;
      int ticks;
      gap_choice = '{0, 2, 18};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_gap_max = 5;
      rsp_gap_max  = 5;

      // mode A at register defaults
      push_beat(ipk_pkg::OP_TICK, 1'b1, 1'b1);
      push_beat(ipk_pkg::OP_PADDLE, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_PADDLE, 1'b1, 1'b0);
      push_beat(ipk_pkg::OP_PADDLE, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b1);
      push_beat(ipk_pkg::OP_TICK, 1'b1, 1'b0);
      push_beat(ipk_pkg::OP_PADDLE, 1'b0, 1'b1);
      push_beat(ipk_pkg::OP_PADDLE, 1'b1, 1'b1);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_PADDLE, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      wait_drained();

      // mode B squeeze
      csr_write(ipk_pkg::REG_MODE_B, 32'd1);
      push_beat(ipk_pkg::OP_PADDLE, 1'b1, 1'b1);
      push_beat(ipk_pkg::OP_PADDLE, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_TICK, 1'b0, 1'b0);
      push_beat(ipk_pkg::OP_PADDLE, 1'b1, 1'b1);
      push_beat(ipk_pkg::OP_PADDLE, 1'b0, 1'b1);
      push_beat(ipk_pkg::OP_TICK, 1'b1, 1'b1);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               mode_v = 0; dot_v = 0; dash_v = 0; gap_v = 0; freq_v = 0;
               send_gap_max = 0;
               rsp_gap_max  = 0;
            end
            1: begin
               mode_v = 1; dot_v = 32'hFFFFFF; dash_v = 32'hFFFFFF; gap_v = 32'hFFFFFF;
               freq_v = 32'hFFF;
               send_gap_max = 18;
               rsp_gap_max  = 18;
            end
            2: begin
               mode_v = 1;
               dot_v  = $urandom_range(32'hFFFFFF);
               dash_v = $urandom_range(32'hFFFFFF);
               gap_v  = $urandom_range(32'hFFFFFF);
               freq_v = 4000;
               send_gap_max = 0;
               rsp_gap_max  = 3;
            end
            default: begin
               mode_v = $urandom_range(1);
               dot_v  = $urandom_range(32'hFFFFFF);
               dash_v = $urandom_range(32'hFFFFFF);
               gap_v  = $urandom_range(32'hFFFFFF);
               freq_v = $urandom_range(32'hFFF);
               send_gap_max = gap_choice[$urandom_range(2)];
               rsp_gap_max  = gap_choice[$urandom_range(2)];
            end
         endcase
         csr_write(ipk_pkg::REG_MODE_B, mode_v);
         csr_write(ipk_pkg::REG_DOT_DUR, dot_v);
         csr_write(ipk_pkg::REG_DASH_DUR, dash_v);
         csr_write(ipk_pkg::REG_GAP_DUR, gap_v);
         csr_write(ipk_pkg::REG_TONE_FREQ, freq_v);

         phase_end = beats_queued + PHASE_BEATS;
         while (beats_queued < phase_end) begin
            if ($urandom_range(4) != 0) begin
               pat = 2'($urandom_range(3, 1));
               push_beat(ipk_pkg::OP_PADDLE, pat[0], pat[1]);
               ticks = $urandom_range(8, 1);
               repeat (ticks) begin
                  if ($urandom_range(5) == 0)
                     push_beat(ipk_pkg::OP_PADDLE, 1'($urandom), 1'($urandom));
                  push_beat(ipk_pkg::OP_TICK, 1'($urandom), 1'($urandom));
               end
               if ($urandom_range(2) != 0) push_beat(ipk_pkg::OP_PADDLE, 1'b0, 1'b0);
               ticks = $urandom_range(5);
               repeat (ticks) push_beat(ipk_pkg::OP_TICK, 1'($urandom), 1'($urandom));
            end else begin
               ticks = $urandom_range(6, 1);
               repeat (ticks) push_beat(1'($urandom), 1'($urandom), 1'($urandom));
            end
         end

         if (p == 2) begin
            rsp_hold_req <= 1'b1;
            @(posedge clock);
            rsp_hold_req <= 1'b0;
         end
         wait_drained();
      end

      if (errors == 0 && expected_tones.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
